// ===== rtl/stb_pkg.sv =====
package stb_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_START = 2'd2,
    FUNC_STOP  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_EXPIRY     = 3'd0,
    KIND_ALLOC      = 3'd1,
    KIND_ALLOC_FAIL = 3'd2,
    KIND_ACK        = 3'd3,
    KIND_BAD        = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_EVAL  = 2'd2,
    ST_FLUSH = 2'd3
  } state_t;

  // most expiry transfers reported for one tick
  localparam logic [4:0] MAX_EXP = 5'd16;

  typedef struct packed {
    logic accept;
    logic eval_commit;
    logic flush_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic any_timers;
    logic eval_stall;
    logic scan_last;
    logic pend_after;
  } sts_t;

endpackage

// ===== rtl/stb_if.sv =====
interface stb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  timer_id;
  logic [15:0] period;

  modport source (output valid, output func, output timer_id, output period, input ready);
  modport sink   (input valid, input func, input timer_id, input period, output ready);
endinterface

interface stb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [3:0] timer_index;
  logic       last;

  modport source (output valid, output kind, output timer_index, output last, input ready);
  modport sink   (input valid, input kind, input timer_index, input last, output ready);
endinterface

// ===== rtl/stb_ctrl.sv =====
module stb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      func,
  input  stb_pkg::sts_t   sts,
  output logic            in_ready,
  output stb_pkg::cmd_t   cmd,
  output stb_pkg::state_t state
);

  stb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.eval_commit = 1'b0;
    cmd.flush_load  = 1'b0;
    unique case (state_r)
      stb_pkg::ST_IDLE: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept && (func == stb_pkg::FUNC_TICK) && sts.any_timers) begin
          state_nxt = stb_pkg::ST_READ;
        end
      end
      stb_pkg::ST_READ: begin
        state_nxt = stb_pkg::ST_EVAL;
      end
      stb_pkg::ST_EVAL: begin
        if (!sts.eval_stall) begin
          cmd.eval_commit = 1'b1;
          if (!sts.scan_last) begin
            state_nxt = stb_pkg::ST_READ;
          end else if (sts.pend_after) begin
            state_nxt = stb_pkg::ST_FLUSH;
          end else begin
            state_nxt = stb_pkg::ST_IDLE;
          end
        end
      end
      stb_pkg::ST_FLUSH: begin
        cmd.flush_load = sts.out_free;
        if (sts.out_free) begin
          state_nxt = stb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stb_pkg::ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

// ===== rtl/stb_datapath.sv =====
module stb_datapath #(
  parameter int NUM_TIMERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stb_pkg::cmd_t cmd,
  input  logic [1:0]    func,
  input  logic [3:0]    timer_id,
  input  logic [15:0]   period,
  input  logic          out_ready,
  output stb_pkg::sts_t sts,
  output logic          out_valid,
  output logic [2:0]    out_kind,
  output logic [3:0]    out_timer_index,
  output logic          out_last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;

  logic [15:0] per_mem [NUM_TIMERS];
  logic [15:0] cnt_mem [NUM_TIMERS];
  logic [15:0] per_rd_r, cnt_rd_r;

  logic [NUM_TIMERS-1:0] run_r;
  logic [CNT_W-1:0]      alloc_cnt_r;
  logic [IDX_W-1:0]      idx_r;
  logic [4:0]            n_r;
  logic                  pend_valid_r;
  logic [3:0]            pend_idx_r;
  logic                  out_valid_r;
  logic [2:0]            out_kind_r;
  logic [3:0]            out_index_r;
  logic                  out_last_r;

  stb_pkg::func_t   op;
  logic [CMP_W-1:0] id_ext, cnt_ext;
  logic [EXT_W-1:0] idx_ext;
  logic [IDX_W-1:0] id_addr, alloc_addr, wr_addr;
  logic             id_ok, full, out_free;
  logic             do_alloc, do_start, do_stop, is_tick, acc_nt;
  logic [15:0]      cnt_inc, per_wdata, cnt_wdata;
  logic             per_we, cnt_we;
  logic             running, expired, exp_rep, emit_mid, out_load;
  logic [2:0]       load_kind;
  logic [3:0]       load_index;
  logic             load_last;

  assign op         = stb_pkg::func_t'(func);
  assign id_ext     = CMP_W'(timer_id);
  assign cnt_ext    = CMP_W'(alloc_cnt_r);
  assign idx_ext    = EXT_W'(idx_r);
  assign id_addr    = id_ext[IDX_W-1:0];
  assign alloc_addr = alloc_cnt_r[IDX_W-1:0];
  assign id_ok      = id_ext < cnt_ext;
  assign full       = alloc_cnt_r == CNT_W'(NUM_TIMERS);
  assign out_free   = !out_valid_r || out_ready;

  assign is_tick  = cmd.accept && (op == stb_pkg::FUNC_TICK);
  assign acc_nt   = cmd.accept && (op != stb_pkg::FUNC_TICK);
  assign do_alloc = cmd.accept && (op == stb_pkg::FUNC_ALLOC) && !full;
  assign do_start = cmd.accept && (op == stb_pkg::FUNC_START) && id_ok;
  assign do_stop  = cmd.accept && (op == stb_pkg::FUNC_STOP) && id_ok;

  // scan evaluation on the word read for idx_r
  assign running  = run_r[idx_r];
  assign cnt_inc  = cnt_rd_r + 16'd1;
  assign expired  = running && (cnt_inc >= per_rd_r);
  assign exp_rep  = expired && (n_r < stb_pkg::MAX_EXP);
  assign emit_mid = cmd.eval_commit && exp_rep && pend_valid_r;

  // single write port per store
  always_comb begin
    per_we    = 1'b0;
    cnt_we    = 1'b0;
    wr_addr   = idx_r;
    per_wdata = 16'd0;
    cnt_wdata = 16'd0;
    priority if (do_alloc) begin
      per_we  = 1'b1;
      cnt_we  = 1'b1;
      wr_addr = alloc_addr;
    end else if (do_start) begin
      per_we    = 1'b1;
      cnt_we    = 1'b1;
      wr_addr   = id_addr;
      per_wdata = period;
    end else if (do_stop) begin
      per_we  = 1'b1;
      wr_addr = id_addr;
    end else if (cmd.eval_commit && running) begin
      cnt_we    = 1'b1;
      cnt_wdata = expired ? 16'd0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[wr_addr] <= per_wdata;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    per_rd_r <= per_mem[idx_r];
    cnt_rd_r <= cnt_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= '0;
      alloc_cnt_r  <= '0;
      idx_r        <= '0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (do_alloc) begin
        run_r[alloc_addr] <= 1'b0;
        alloc_cnt_r       <= alloc_cnt_r + CNT_W'(1);
      end
      if (do_start) begin
        run_r[id_addr] <= 1'b1;
      end
      if (do_stop) begin
        run_r[id_addr] <= 1'b0;
      end
      if (is_tick) begin
        idx_r        <= '0;
        n_r          <= '0;
        pend_valid_r <= 1'b0;
      end else if (cmd.eval_commit) begin
        idx_r <= idx_r + IDX_W'(1);
        if (exp_rep) begin
          n_r          <= n_r + 5'd1;
          pend_valid_r <= 1'b1;
        end
      end else if (cmd.flush_load) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_commit && exp_rep) begin
      pend_idx_r <= idx_ext[3:0];
    end
  end

  // result selection
  always_comb begin
    load_kind  = stb_pkg::KIND_EXPIRY;
    load_index = pend_idx_r;
    load_last  = 1'b1;
    if (acc_nt) begin
      unique case (op)
        stb_pkg::FUNC_ALLOC: begin
          load_kind  = full ? stb_pkg::KIND_ALLOC_FAIL : stb_pkg::KIND_ALLOC;
          load_index = full ? 4'd0 : cnt_ext[3:0];
        end
        default: begin
          load_kind  = id_ok ? stb_pkg::KIND_ACK : stb_pkg::KIND_BAD;
          load_index = timer_id;
        end
      endcase
    end else if (emit_mid) begin
      load_last = 1'b0;
    end
  end

  assign out_load = acc_nt || emit_mid || cmd.flush_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= load_kind;
      out_index_r <= load_index;
      out_last_r  <= load_last;
    end
  end

  assign sts.out_free   = out_free;
  assign sts.any_timers = alloc_cnt_r != '0;
  assign sts.eval_stall = exp_rep && pend_valid_r && !out_free;
  assign sts.scan_last  = (CNT_W'(idx_r) + CNT_W'(1)) == alloc_cnt_r;
  assign sts.pend_after = pend_valid_r || exp_rep;

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_timer_index = out_index_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/software_timer_bank.sv =====
// bank of periodic timers sharing one tick input
// in_ch carries one operation per transfer: func selects tick, allocate,
// start (timer_id, period) or stop (timer_id)
// out_ch carries result transfers: kind, timer_index and last, where last
// marks the final result caused by one operation
// allocate, start and stop give one result, registered and shown in the cycle
// after the input transfer; the next operation may follow in the next cycle
// if the receiver takes the result; a tick walks the allocated timers one
// at a time, each in a read state (read of the period and count stores) and
// then an evaluate state (update and write back); the final expiry is loaded
// from a flush state, and input is taken again when the scan returns to idle
// a tick with no expiring timer gives no result
// the period and count stores have one read port, which sets the tick rate
// reset clears the allocation count and all running flags; store entries
// are cleared when a timer is allocated, so no clearing pass is needed
// a stalled receiver holds the output register and input is held off while
// a result waits; a tick scan pauses when a further expiry is found while
// one is still pending and the output register is not free
module software_timer_bank #(
  parameter int NUM_TIMERS = 16
) (
  input logic      clk,
  input logic      rst_n,
  stb_in_if.sink   in_ch,
  stb_out_if.source out_ch
);

  stb_pkg::cmd_t   cmd;
  stb_pkg::sts_t   sts;
  stb_pkg::state_t ctrl_state;

  // sequencing of operations and the tick scan
  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .func     (in_ch.func),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .state    (ctrl_state)
  );

  // timer stores, scan registers and result register
  stb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .func            (in_ch.func),
    .timer_id        (in_ch.timer_id),
    .period          (in_ch.period),
    .out_ready       (out_ch.ready),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_timer_index (out_ch.timer_index),
    .out_last        (out_ch.last)
  );

  // single result operations show their result in the next cycle
  a_single_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.func != stb_pkg::FUNC_TICK)) |=> out_ch.valid)
    else $error("no result after allocate, start or stop");

  // no input transfer while a tick scan is in progress
  a_busy_no_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_state != stb_pkg::ST_IDLE) |-> !in_ch.ready)
    else $error("input taken during tick scan");

  // only expiries can be followed by further results
  a_mid_is_expiry : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (out_ch.kind == stb_pkg::KIND_EXPIRY))
    else $error("non-final result that is not an expiry");

  // a tick scan stays in flush until its pending expiry can enter the output register
  a_flush_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_state == stb_pkg::ST_FLUSH && out_ch.valid && !out_ch.ready)
      |=> (ctrl_state == stb_pkg::ST_FLUSH))
    else $error("scan left flush with the final expiry still pending");

endmodule

// ===== test/tb_software_timer_bank.sv =====
module tb_software_timer_bank;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT         = 16;
  localparam int RAND_ITEMS = 340;
  // quiet cycles allowed: covers the long receiver hold-off plus a full tick scan
  localparam int WATCHDOG   = 3000;
  // a full scan of the bank plus the final expiry transfer, with some margin
  localparam int DRAIN      = 2 * NT + 8;
  localparam int HOLD_OFF   = 400;

  typedef struct packed {
    stb_pkg::kind_t kind;
    logic [3:0]     idx;
    logic           last;
  } result_t;

  // one directed row; typed rows carry their single result, the rest go to the predictor
  typedef struct {
    stb_pkg::func_t func;
    logic [3:0]     id;
    logic [15:0]    per;
    bit             typed;
    stb_pkg::kind_t kind;
    logic [3:0]     idx;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stb_in_if  in_ch ();
  stb_out_if out_ch ();

  software_timer_bank #(
    .NUM_TIMERS(NT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predicted bank state
  logic [15:0] per_mem [NT];
  logic [15:0] cnt_mem [NT];
  bit          run_mem [NT];
  int          n_alloc = 0;

  result_t step_res [$];
  result_t pending_results [$];
  int      errors = 0;
  int      results_seen = 0;
  bit      holding_off = 1'b0;
  int      send_calm = 0;

  // side information travelling with the item on the input channel
  bit             cur_typed = 1'b0;
  stb_pkg::kind_t cur_kind = stb_pkg::KIND_EXPIRY;
  logic [3:0]     cur_idx = '0;

  stim_row_t directed_tab [22] = '{
    // start and stop before any allocation: bad index
    '{stb_pkg::FUNC_START, 4'd0,  16'd5,    1'b1, stb_pkg::KIND_BAD,    4'd0},
    '{stb_pkg::FUNC_STOP,  4'd15, 16'd0,    1'b1, stb_pkg::KIND_BAD,    4'd15},
    // tick on an empty bank gives nothing, ignored fields at their top
    '{stb_pkg::FUNC_TICK,  4'd15, 16'hFFFF, 1'b0, stb_pkg::KIND_EXPIRY, 4'd0},
    '{stb_pkg::FUNC_ALLOC, 4'd0,  16'd0,    1'b1, stb_pkg::KIND_ALLOC,  4'd0},
    '{stb_pkg::FUNC_START, 4'd1,  16'hFFFF, 1'b1, stb_pkg::KIND_BAD,    4'd1},
    // period of zero expires on every tick
    '{stb_pkg::FUNC_START, 4'd0,  16'd0,    1'b1, stb_pkg::KIND_ACK,    4'd0},
    '{stb_pkg::FUNC_TICK,  4'd0,  16'd0,    1'b0, stb_pkg::KIND_EXPIRY, 4'd0},
    '{stb_pkg::FUNC_ALLOC, 4'd15, 16'hFFFF, 1'b1, stb_pkg::KIND_ALLOC,  4'd1},
    '{stb_pkg::FUNC_START, 4'd1,  16'hFFFF, 1'b1, stb_pkg::KIND_ACK,    4'd1},
    '{stb_pkg::FUNC_TICK,  4'd0,  16'd0,    1'b0, stb_pkg::KIND_EXPIRY, 4'd0},
    // stop keeps the count but halts the timer
    '{stb_pkg::FUNC_STOP,  4'd0,  16'hFFFF, 1'b1, stb_pkg::KIND_ACK,    4'd0},
    '{stb_pkg::FUNC_TICK,  4'd0,  16'd0,    1'b0, stb_pkg::KIND_EXPIRY, 4'd0},
    '{stb_pkg::FUNC_START, 4'd0,  16'd1,    1'b1, stb_pkg::KIND_ACK,    4'd0},
    '{stb_pkg::FUNC_ALLOC, 4'd7,  16'h1234, 1'b1, stb_pkg::KIND_ALLOC,  4'd2},
    '{stb_pkg::FUNC_START, 4'd2,  16'd2,    1'b1, stb_pkg::KIND_ACK,    4'd2},
    '{stb_pkg::FUNC_TICK,  4'd0,  16'd0,    1'b0, stb_pkg::KIND_EXPIRY, 4'd0},
    '{stb_pkg::FUNC_TICK,  4'd0,  16'd0,    1'b0, stb_pkg::KIND_EXPIRY, 4'd0},
    '{stb_pkg::FUNC_STOP,  4'd1,  16'd0,    1'b1, stb_pkg::KIND_ACK,    4'd1},
    '{stb_pkg::FUNC_START, 4'd1,  16'd0,    1'b1, stb_pkg::KIND_ACK,    4'd1},
    // several expiries in one tick, last one marked
    '{stb_pkg::FUNC_TICK,  4'd0,  16'd0,    1'b0, stb_pkg::KIND_EXPIRY, 4'd0},
    '{stb_pkg::FUNC_TICK,  4'd0,  16'd0,    1'b0, stb_pkg::KIND_EXPIRY, 4'd0},
    '{stb_pkg::FUNC_STOP,  4'd3,  16'd0,    1'b1, stb_pkg::KIND_BAD,    4'd3}
  };

  // gap lengths: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // small periods keep expiries frequent, a share spans the full range
  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 4));
    if (r < 70) return 16'($urandom_range(5, 20));
    if (r < 80) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  // applies one operation to the predicted bank, leaves its results in step_res
  function automatic void advance_bank(stb_pkg::func_t f, logic [3:0] id,
                                       logic [15:0] per);
    step_res = {};
    case (f)
      stb_pkg::FUNC_TICK: begin
        for (int i = 0; i < n_alloc; i++) begin
          if (run_mem[i]) begin
            cnt_mem[i] = cnt_mem[i] + 16'd1;
            if (cnt_mem[i] >= per_mem[i]) begin
              cnt_mem[i] = '0;
              step_res.push_back('{stb_pkg::KIND_EXPIRY, 4'(i), 1'b0});
            end
          end
        end
        if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
      end
      stb_pkg::FUNC_ALLOC: begin
        if (n_alloc < NT) begin
          per_mem[n_alloc] = '0;
          cnt_mem[n_alloc] = '0;
          run_mem[n_alloc] = 1'b0;
          step_res.push_back('{stb_pkg::KIND_ALLOC, 4'(n_alloc), 1'b1});
          n_alloc++;
        end else begin
          step_res.push_back('{stb_pkg::KIND_ALLOC_FAIL, 4'd0, 1'b1});
        end
      end
      default: begin
        if (id >= n_alloc) begin
          step_res.push_back('{stb_pkg::KIND_BAD, id, 1'b1});
        end else begin
          if (f == stb_pkg::FUNC_START) begin
            per_mem[id] = per;
            cnt_mem[id] = '0;
            run_mem[id] = 1'b1;
          end else begin
            per_mem[id] = '0;
            run_mem[id] = 1'b0;
          end
          step_res.push_back('{stb_pkg::KIND_ACK, id, 1'b1});
        end
      end
    endcase
  endfunction

  // offer one operation and hold it until the transfer
  task automatic send_op(stb_pkg::func_t f, logic [3:0] id, logic [15:0] per,
                         bit typed, stb_pkg::kind_t k, logic [3:0] idx);
    int gap;
    gap = 0;
    if (!holding_off && send_calm == 0 && $urandom_range(0, 99) < 35) gap = pick_gap();
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(0, 99) < 4) send_calm = $urandom_range(15, 40);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.timer_id <= id;
    in_ch.period   <= per;
    cur_typed      <= typed;
    cur_kind       <= k;
    cur_idx        <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // reset, then directed rows, then random operations
  initial begin
    int             gen_alloc;
    int             r;
    stb_pkg::func_t f;
    logic [3:0]     id;
    logic [15:0]    per;
    in_ch.valid    = 1'b0;
    in_ch.func     = stb_pkg::FUNC_TICK;
    in_ch.timer_id = '0;
    in_ch.period   = '0;
    gen_alloc = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_tab[n]) begin
      if (directed_tab[n].func == stb_pkg::FUNC_ALLOC && gen_alloc < NT) gen_alloc++;
      send_op(directed_tab[n].func, directed_tab[n].id, directed_tab[n].per,
              directed_tab[n].typed, directed_tab[n].kind, directed_tab[n].idx);
    end

    // ticks, allocations, and start and stop mostly on allocated timers, some on any
    // index; the bank fills up over the run so that allocation failures follow
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r   = $urandom_range(0, 99);
      id  = 4'($urandom_range(0, 15));
      per = 16'($urandom_range(0, 65535));
      if (r < 8 || (n >= 250 && gen_alloc < NT)) begin
        f = stb_pkg::FUNC_ALLOC;
      end else if (r < 50) begin
        f = stb_pkg::FUNC_TICK;
      end else begin
        f = ($urandom_range(0, 99) < 65) ? stb_pkg::FUNC_START : stb_pkg::FUNC_STOP;
        if (gen_alloc > 0 && $urandom_range(0, 99) < 85) begin
          id = 4'($urandom_range(0, gen_alloc - 1));
        end
        per = pick_period();
      end
      if (f == stb_pkg::FUNC_ALLOC && gen_alloc < NT) gen_alloc++;
      send_op(f, id, per, 1'b0, stb_pkg::KIND_EXPIRY, 4'd0);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** software_timer_bank: PASSED **");
    end else begin
      $display("** software_timer_bank: FAILED **");
    end
    $finish;
  end

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int gap_left;
    int calm_left;
    bit pressed;
    gap_left  = 0;
    calm_left = 0;
    pressed   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && results_seen >= 40) begin
        pressed     = 1'b1;
        holding_off = 1'b1;
        gap_left    = HOLD_OFF;
      end
      if (gap_left > 0) begin
        out_ch.ready <= 1'b0;
        gap_left--;
        if (gap_left == 0) holding_off = 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 5) calm_left = $urandom_range(20, 60);
        else if ($urandom_range(0, 99) < 30) gap_left = pick_gap();
      end
    end
  end

  // monitor: check result transfers, predict on input transfers
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind %0d index %0d last %0b",
                   $realtime, out_ch.kind, out_ch.timer_index, out_ch.last);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.kind !== want.kind) begin
            errors++;
            $display("%0t: kind expected %0d actual %0d", $realtime, want.kind, out_ch.kind);
          end
          if (out_ch.timer_index !== want.idx) begin
            errors++;
            $display("%0t: timer_index expected %0d actual %0d",
                     $realtime, want.idx, out_ch.timer_index);
          end
          if (out_ch.last !== want.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $realtime, want.last, out_ch.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_bank(stb_pkg::func_t'(in_ch.func), in_ch.timer_id, in_ch.period);
        if (cur_typed) pending_results.push_back('{cur_kind, cur_idx, 1'b1});
        else foreach (step_res[k]) pending_results.push_back(step_res[k]);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG);
      $display("** software_timer_bank: FAILED **");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/stb_pkg.sv
rtl/stb_if.sv
rtl/stb_ctrl.sv
rtl/stb_datapath.sv
rtl/software_timer_bank.sv
test/tb_software_timer_bank.sv
